FILE: hw/rtl/ebrs_pkg.sv
// Package for the event batch receive sequencer.
// Holds status, mode and op codes, window sizing and the window port types.
// No dependencies.
`default_nettype none

package ebrs_pkg;

  localparam int unsigned WIN_DEPTH = 16;
  localparam int unsigned WIN_IDX_W = (WIN_DEPTH > 1) ? $clog2(WIN_DEPTH) : 1;

  localparam int unsigned SEQ_W = 64;

  // Item kinds, carried on tuser
  localparam logic [1:0] OP_BATCH    = 2'd0;
  localparam logic [1:0] OP_BASELINE = 2'd1;
  localparam logic [1:0] OP_SNAPSHOT = 2'd2;
  localparam logic [1:0] OP_SESSION  = 2'd3;

  // Stream modes
  localparam logic [1:0] MODE_AWAIT  = 2'd0;
  localparam logic [1:0] MODE_SYNCED = 2'd1;
  localparam logic [1:0] MODE_SNAP   = 2'd2;

  // Result status codes
  localparam logic [3:0] STAT_APPLIED   = 4'd0;
  localparam logic [3:0] STAT_DUPLICATE = 4'd1;
  localparam logic [3:0] STAT_STALE     = 4'd2;
  localparam logic [3:0] STAT_IDENTITY  = 4'd3;
  localparam logic [3:0] STAT_BAD_ID    = 4'd4;
  localparam logic [3:0] STAT_COUNT     = 4'd5;
  localparam logic [3:0] STAT_SHAPE     = 4'd6;
  localparam logic [3:0] STAT_PRINT     = 4'd7;
  localparam logic [3:0] STAT_SNAPSHOT  = 4'd8;
  localparam logic [3:0] STAT_OVERLAP   = 4'd9;
  localparam logic [3:0] STAT_CONFLICT  = 4'd10;
  localparam logic [3:0] STAT_GAP       = 4'd11;
  localparam logic [3:0] STAT_CONSUMER  = 4'd12;

  // One applied range in the window
  typedef struct packed {
    logic [SEQ_W-1:0] rng_start;
    logic [SEQ_W-1:0] rng_last;
    logic [SEQ_W-1:0] rng_print;
  } win_entry_t;

  // Sequencer to window controls
  typedef struct packed {
    logic                 wr_en;
    logic                 clr;
    logic                 rd_en;
    logic [WIN_IDX_W-1:0] rd_age;   // 0 = newest entry
  } win_ctl_t;

endpackage

`default_nettype wire

FILE: hw/rtl/ebrs_alu.sv
// Shared 64-bit compare/add unit of the receive sequencer.
// Depends on ebrs_pkg for the sequence width.
`default_nettype none

module ebrs_alu import ebrs_pkg::*; (
  input  wire logic [SEQ_W-1:0] a_i,
  input  wire logic [SEQ_W-1:0] b_i,
  output logic                  eq_o,
  output logic                  lt_o,
  output logic [SEQ_W-1:0]      sum_o
);

  assign eq_o  = (a_i == b_i);
  assign lt_o  = (a_i < b_i);
  assign sum_o = a_i + b_i;   // wraps modulo 2^64

endmodule

`default_nettype wire

FILE: hw/rtl/ebrs_window.sv
// Ring window of applied ranges: entry memory, per-entry valid bits, write pointer.
// Read by age from the newest entry, data registered. Depends on ebrs_pkg.
`default_nettype none

module ebrs_window import ebrs_pkg::*; (
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  input  wire win_ctl_t   ctl_i,
  input  wire win_entry_t wr_data_i,
  output win_entry_t      rd_data_o,
  output logic            rd_valid_o
);

  win_entry_t               mem_q [WIN_DEPTH];
  logic [WIN_DEPTH-1:0]     valid_q;
  logic [WIN_IDX_W-1:0]     next_q;
  logic [WIN_IDX_W-1:0]     next_inc;
  logic [WIN_IDX_W:0]       slot_sum;
  logic [WIN_IDX_W-1:0]     rd_slot;
  win_entry_t               rd_data_q;
  logic                     rd_valid_q;

  // slot = (next - 1 - age) mod depth, kept positive
  always_comb begin
    slot_sum = {1'b0, next_q} + (WIN_IDX_W+1)'(WIN_DEPTH - 1) - {1'b0, ctl_i.rd_age};
    if (slot_sum >= (WIN_IDX_W+1)'(WIN_DEPTH)) begin
      rd_slot = WIN_IDX_W'(slot_sum - (WIN_IDX_W+1)'(WIN_DEPTH));
    end else begin
      rd_slot = slot_sum[WIN_IDX_W-1:0];
    end
  end

  assign next_inc = (next_q == WIN_IDX_W'(WIN_DEPTH - 1)) ? '0 : next_q + WIN_IDX_W'(1);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q    <= '0;
      next_q     <= '0;
      rd_valid_q <= 1'b0;
    end else begin
      if (ctl_i.clr) begin
        valid_q <= '0;
        next_q  <= '0;
      end else if (ctl_i.wr_en) begin
        valid_q[next_q] <= 1'b1;
        next_q          <= next_inc;
      end
      if (ctl_i.rd_en) begin
        rd_valid_q <= valid_q[rd_slot];
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctl_i.wr_en) begin
      mem_q[next_q] <= wr_data_i;
    end
    if (ctl_i.rd_en) begin
      rd_data_q <= mem_q[rd_slot];
    end
  end

  assign rd_data_o  = rd_data_q;
  assign rd_valid_o = rd_valid_q;

endmodule

`default_nettype wire

FILE: hw/rtl/event_batch_receive_sequencer_top.sv
// Event batch receive sequencer: top level with the check sequencer,
// config registers and output register. Uses ebrs_pkg, ebrs_alu, ebrs_window.
//
// Usage:
//   Input stream (s_axis_*): one beat per item, kind on tuser (batch header,
//   set baseline, demand snapshot, new session), header fields on tdata.
//   Output stream (m_axis_*): one beat per item with status, deliver flag,
//   stream mode and confirmed sequence after the item.
//   APB port: owner_id at 0x0, max_events at 0x4; write only while idle.
// Timing:
//   One item at a time; tready is high only while the sequencer is idle.
//   Control events go from dispatch straight to the output step. A batch
//   header walks its checks through one shared 64-bit compare/add unit,
//   one check per cycle; a duplicate lookup reads the window newest first,
//   one entry per cycle through the registered window port, up to all 16
//   entries, then compares end and print.
// Reset: mode awaiting baseline, confirmed 0, window empty, owner_id 0,
//   max_events 256. No clearing pass.
// Stall: a result waits in the output register; the sequencer holds in its
//   final step until that register is free, so no beat is lost.
`default_nettype none

module event_batch_receive_sequencer_top import ebrs_pkg::*; (
  input  wire logic         clk_i,
  input  wire logic         rst_ni,
  // Input stream
  input  wire logic         s_axis_tvalid,
  output logic              s_axis_tready,
  // tdata from bit 0: component(32), first_seq(64), last_seq(64),
  // num_events(32), claimed_print(64), computed_print(64), consumer_ok(1),
  // baseline_seq(64), zero pad(7)
  input  wire logic [391:0] s_axis_tdata,
  // tuser: op(2)
  input  wire logic [1:0]   s_axis_tuser,
  // Output stream
  output logic              m_axis_tvalid,
  input  wire logic         m_axis_tready,
  // tdata from bit 0: status(4), deliver(1), stream_mode(2),
  // confirmed_out(64), zero pad(1)
  output logic [71:0]       m_axis_tdata,
  // APB configuration port
  input  wire logic         psel,
  input  wire logic         penable,
  input  wire logic         pwrite,
  input  wire logic [2:0]   paddr,
  input  wire logic [31:0]  pwdata,
  output logic [31:0]       prdata,
  output logic              pready
);

  localparam logic [3:0] ST_IDLE  = 4'd0;
  localparam logic [3:0] ST_DISP  = 4'd1;
  localparam logic [3:0] ST_ID    = 4'd2;
  localparam logic [3:0] ST_CNT   = 4'd3;
  localparam logic [3:0] ST_SUM   = 4'd4;
  localparam logic [3:0] ST_SHAPE = 4'd5;
  localparam logic [3:0] ST_PRINT = 4'd6;
  localparam logic [3:0] ST_SEQ   = 4'd7;
  localparam logic [3:0] ST_OVL   = 4'd8;
  localparam logic [3:0] ST_SCAN  = 4'd9;
  localparam logic [3:0] ST_END   = 4'd10;
  localparam logic [3:0] ST_WPR   = 4'd11;
  localparam logic [3:0] ST_OUT   = 4'd12;

  localparam logic REG_OWNER = 1'b0;
  localparam logic REG_MAX   = 1'b1;

  // Config registers
  logic [31:0] owner_q;
  logic [15:0] max_q;

  // Captured input beat
  logic [1:0]       op_q;
  logic [31:0]      comp_q;
  logic [SEQ_W-1:0] first_q;
  logic [SEQ_W-1:0] last_q;
  logic [31:0]      cnt_q;
  logic [SEQ_W-1:0] claim_q;
  logic [SEQ_W-1:0] cprint_q;
  logic             ok_q;
  logic [SEQ_W-1:0] base_q;

  // Sequencer state
  logic [3:0]           state_q, state_d;
  logic [1:0]           mode_q, mode_d;
  logic [SEQ_W-1:0]     conf_q, conf_d;
  logic [3:0]           status_q, status_d;
  logic                 deliver_q, deliver_d;
  logic [SEQ_W-1:0]     sum_q, sum_d;
  logic [WIN_IDX_W-1:0] age_q, age_d;

  // Output register
  logic        m_valid_q;
  logic [71:0] m_data_q;

  // Shared unit and window
  logic [SEQ_W-1:0] alu_a, alu_b, alu_sum;
  logic             alu_eq, alu_lt;
  win_ctl_t         wctl;
  win_entry_t       wr_entry, rd_entry;
  logic             rd_valid;

  logic in_accept, cfg_wr, out_load;

  assign s_axis_tready = (state_q == ST_IDLE);
  assign in_accept     = s_axis_tvalid && s_axis_tready;
  assign pready        = 1'b1;
  assign cfg_wr        = psel && penable && pwrite && pready;
  assign out_load      = (state_q == ST_OUT) && (!m_valid_q || m_axis_tready);

  always_comb begin
    unique case (paddr[2])
      REG_OWNER: prdata = owner_q;
      REG_MAX:   prdata = {16'd0, max_q};
      default:   prdata = '0;
    endcase
  end

  ebrs_alu u_alu (
    .a_i   (alu_a),
    .b_i   (alu_b),
    .eq_o  (alu_eq),
    .lt_o  (alu_lt),
    .sum_o (alu_sum)
  );

  assign wr_entry = '{rng_start: first_q, rng_last: last_q, rng_print: claim_q};

  ebrs_window u_window (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .ctl_i      (wctl),
    .wr_data_i  (wr_entry),
    .rd_data_o  (rd_entry),
    .rd_valid_o (rd_valid)
  );

  always_comb begin
    state_d   = state_q;
    mode_d    = mode_q;
    conf_d    = conf_q;
    status_d  = status_q;
    deliver_d = deliver_q;
    sum_d     = sum_q;
    age_d     = age_q;
    wctl      = '0;
    alu_a     = '0;
    alu_b     = '0;
    unique case (state_q)
      ST_IDLE: begin
        if (s_axis_tvalid) begin
          state_d = ST_DISP;
        end
      end
      ST_DISP: begin
        status_d  = STAT_APPLIED;
        deliver_d = 1'b0;
        unique case (op_q)
          OP_BATCH: begin
            state_d = ST_ID;
          end
          OP_BASELINE: begin
            conf_d   = base_q;
            mode_d   = MODE_SYNCED;
            wctl.clr = 1'b1;
            state_d  = ST_OUT;
          end
          OP_SNAPSHOT: begin
            if (mode_q != MODE_AWAIT) begin
              mode_d = MODE_SNAP;
            end
            state_d = ST_OUT;
          end
          OP_SESSION: begin
            conf_d   = '0;
            mode_d   = MODE_AWAIT;
            wctl.clr = 1'b1;
            state_d  = ST_OUT;
          end
          default: state_d = ST_OUT;
        endcase
      end
      ST_ID: begin
        alu_a = {32'd0, comp_q};
        alu_b = {32'd0, owner_q};
        if (!alu_eq) begin
          status_d = STAT_IDENTITY;
          state_d  = ST_OUT;
        end else if (comp_q == 32'd0) begin
          status_d = STAT_BAD_ID;
          state_d  = ST_OUT;
        end else begin
          state_d = ST_CNT;
        end
      end
      ST_CNT: begin
        // max < count
        alu_a = {48'd0, max_q};
        alu_b = {32'd0, cnt_q};
        if (cnt_q == 32'd0 || alu_lt) begin
          status_d = STAT_COUNT;
          state_d  = ST_OUT;
        end else begin
          state_d = ST_SUM;
        end
      end
      ST_SUM: begin
        alu_a   = first_q;
        alu_b   = {32'd0, cnt_q};
        sum_d   = alu_sum;
        state_d = ST_SHAPE;
      end
      ST_SHAPE: begin
        alu_a = last_q;
        alu_b = sum_q;
        if (!alu_eq) begin
          status_d = STAT_SHAPE;
          state_d  = ST_OUT;
        end else begin
          state_d = ST_PRINT;
        end
      end
      ST_PRINT: begin
        alu_a = claim_q;
        alu_b = cprint_q;
        if (!alu_eq) begin
          status_d = STAT_PRINT;
          state_d  = ST_OUT;
        end else if (mode_q != MODE_SYNCED) begin
          status_d = STAT_SNAPSHOT;
          state_d  = ST_OUT;
        end else begin
          state_d = ST_SEQ;
        end
      end
      ST_SEQ: begin
        alu_a = first_q;
        alu_b = conf_q;
        if (alu_eq) begin
          deliver_d = 1'b1;
          state_d   = ST_OUT;
          if (!ok_q) begin
            mode_d   = MODE_SNAP;
            status_d = STAT_CONSUMER;
          end else begin
            conf_d     = last_q;
            wctl.wr_en = 1'b1;
            status_d   = STAT_APPLIED;
          end
        end else if (alu_lt) begin
          state_d = ST_OVL;
        end else begin
          mode_d   = MODE_SNAP;
          status_d = STAT_GAP;
          state_d  = ST_OUT;
        end
      end
      ST_OVL: begin
        // confirmed < last: range straddles the confirmed point
        alu_a = conf_q;
        alu_b = last_q;
        if (alu_lt) begin
          status_d = STAT_OVERLAP;
          state_d  = ST_OUT;
        end else begin
          wctl.rd_en  = 1'b1;
          wctl.rd_age = '0;
          age_d       = '0;
          state_d     = ST_SCAN;
        end
      end
      ST_SCAN: begin
        // newest first; read data for age_q is held while it is compared
        alu_a = rd_entry.rng_start;
        alu_b = first_q;
        if (rd_valid && alu_eq) begin
          state_d = ST_END;
        end else if (age_q == WIN_IDX_W'(WIN_DEPTH - 1)) begin
          status_d = STAT_STALE;
          state_d  = ST_OUT;
        end else begin
          wctl.rd_en  = 1'b1;
          wctl.rd_age = age_q + WIN_IDX_W'(1);
          age_d       = age_q + WIN_IDX_W'(1);
        end
      end
      ST_END: begin
        alu_a = rd_entry.rng_last;
        alu_b = last_q;
        if (alu_eq) begin
          state_d = ST_WPR;
        end else begin
          status_d = STAT_CONFLICT;
          state_d  = ST_OUT;
        end
      end
      ST_WPR: begin
        alu_a    = rd_entry.rng_print;
        alu_b    = claim_q;
        status_d = alu_eq ? STAT_DUPLICATE : STAT_CONFLICT;
        state_d  = ST_OUT;
      end
      ST_OUT: begin
        if (!m_valid_q || m_axis_tready) begin
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= ST_IDLE;
      mode_q    <= MODE_AWAIT;
      conf_q    <= '0;
      owner_q   <= '0;
      max_q     <= 16'd256;
      m_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      mode_q  <= mode_d;
      conf_q  <= conf_d;
      if (cfg_wr) begin
        unique case (paddr[2])
          REG_OWNER: owner_q <= pwdata;
          REG_MAX:   max_q   <= pwdata[15:0];
          default:   owner_q <= owner_q;
        endcase
      end
      if (out_load) begin
        m_valid_q <= 1'b1;
      end else if (m_axis_tready) begin
        m_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    status_q  <= status_d;
    deliver_q <= deliver_d;
    sum_q     <= sum_d;
    age_q     <= age_d;
    if (in_accept) begin
      op_q     <= s_axis_tuser;
      comp_q   <= s_axis_tdata[31:0];
      first_q  <= s_axis_tdata[95:32];
      last_q   <= s_axis_tdata[159:96];
      cnt_q    <= s_axis_tdata[191:160];
      claim_q  <= s_axis_tdata[255:192];
      cprint_q <= s_axis_tdata[319:256];
      ok_q     <= s_axis_tdata[320];
      base_q   <= s_axis_tdata[384:321];
    end
    if (out_load) begin
      m_data_q <= {1'b0, conf_q, mode_q, deliver_q, status_q};
    end
  end

  assign m_axis_tvalid = m_valid_q;
  assign m_axis_tdata  = m_data_q;

  // One item in flight: after an accept the input side closes
  a_single_item: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_accept |=> !s_axis_tready)
    else $error("input accepted while an item is in flight");

  // Delivery only for in-order outcomes
  a_deliver_status: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && m_axis_tdata[4]) |->
      (m_axis_tdata[3:0] == STAT_APPLIED || m_axis_tdata[3:0] == STAT_CONSUMER))
    else $error("deliver set on a non in-order result");

  // Ranges are recorded only from the in-order step while synced
  a_record_synced: assert property (@(posedge clk_i) disable iff (!rst_ni)
    wctl.wr_en |-> (state_q == ST_SEQ && mode_q == MODE_SYNCED))
    else $error("window written outside the in-order step");

  // Mode never leaves its three legal codes
  a_mode_legal: assert property (@(posedge clk_i) disable iff (!rst_ni)
    mode_q == MODE_AWAIT || mode_q == MODE_SYNCED || mode_q == MODE_SNAP)
    else $error("stream mode corrupted");

endmodule

`default_nettype wire

FILE: tb/tb_top.sv
`timescale 1ns / 100ps
// Testbench for event_batch_receive_sequencer_top. It sends batch headers and
// control events, predicts every result beat in a local model of the receiver
// and checks each beat. Depends on ebrs_pkg and the sequencer RTL.
module tb_top;
  import ebrs_pkg::*;

  localparam logic [2:0]  REG_OWNER_ID   = 3'h0;
  localparam logic [2:0]  REG_MAX_EVENTS = 3'h4;
  localparam int unsigned LOG_DEPTH      = 24;  // deeper than the window, so replays go stale

  typedef struct {
    logic [1:0]  op;
    logic [31:0] component;
    logic [63:0] first_seq;
    logic [63:0] last_seq;
    logic [31:0] num_events;
    logic [63:0] claimed_print;
    logic [63:0] computed_print;
    logic        consumer_ok;
    logic [63:0] baseline_seq;
  } batch_item_t;

  typedef struct {
    logic [3:0]  status;
    logic        deliver;
    logic [1:0]  mode;
    logic [63:0] confirmed;
  } verdict_t;

  typedef struct {
    logic [63:0] first_seq;
    logic [63:0] last_seq;
    logic [63:0] print;
  } applied_range_t;

  logic         clk_i         = 1'b0;
  logic         rst_ni        = 1'b0;
  logic         s_axis_tvalid = 1'b0;
  wire          s_axis_tready;
  // component, first_seq, last_seq, num_events, claimed_print, computed_print,
  // consumer_ok, baseline_seq, pad (from bit 0)
  logic [391:0] s_axis_tdata  = '0;
  logic [1:0]   s_axis_tuser  = OP_BATCH;   // op
  wire          m_axis_tvalid;
  logic         m_axis_tready = 1'b1;
  // status, deliver, stream_mode, confirmed_out, pad (from bit 0)
  wire  [71:0]  m_axis_tdata;
  logic         psel          = 1'b0;
  logic         penable       = 1'b0;
  logic         pwrite        = 1'b0;
  logic [2:0]   paddr         = '0;
  logic [31:0]  pwdata        = '0;
  wire  [31:0]  prdata;
  wire          pready;

  // receiver model
  logic [1:0]           seq_mode;
  logic [63:0]          seq_confirmed;
  logic [63:0]          win_first [WIN_DEPTH];
  logic [63:0]          win_last  [WIN_DEPTH];
  logic [63:0]          win_print [WIN_DEPTH];
  logic                 win_ok    [WIN_DEPTH];
  logic [WIN_IDX_W-1:0] win_ptr;
  logic [31:0]          cfg_owner      = '0;
  logic [15:0]          cfg_max_events = 16'd256;

  verdict_t       pending_verdicts [$];
  applied_range_t applied_log [$];
  bit             idle_en = 1'b1;
  int             stall_left;
  int             mismatch_cnt;
  int             items_sent;
  int             results_checked;
  int             cfg_writes;
  int             status_hits [16];

  always begin
    #2 clk_i = 1'b1;
    #2 clk_i = 1'b0;
  end

  event_batch_receive_sequencer_top dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .psel          (psel),
    .penable       (penable),
    .pwrite        (pwrite),
    .paddr         (paddr),
    .pwdata        (pwdata),
    .prdata        (prdata),
    .pready        (pready)
  );

  function automatic logic [63:0] rand64();
    return {$urandom, $urandom};
  endfunction

  function automatic void flush_window();
    foreach (win_ok[i]) win_ok[i] = 1'b0;
    win_ptr = '0;
    applied_log.delete();
  endfunction

  function automatic void force_snapshot();
    if (seq_mode != MODE_AWAIT) seq_mode = MODE_SNAP;
  endfunction

  // Next receiver state and result beat for one accepted item
  function automatic verdict_t advance_stream(input batch_item_t it);
    verdict_t       v;
    applied_range_t rec;
    logic [63:0]    tail;
    logic [WIN_IDX_W-1:0] slot;
    int             hit;
    int             k;
    v.status  = STAT_APPLIED;
    v.deliver = 1'b0;
    tail = it.first_seq + {32'd0, it.num_events};
    case (it.op)
      OP_BATCH: begin
        if (it.component != cfg_owner) v.status = STAT_IDENTITY;
        else if (it.component == '0) v.status = STAT_BAD_ID;
        else if (it.num_events == '0 || it.num_events > {16'd0, cfg_max_events})
          v.status = STAT_COUNT;
        else if (it.last_seq != tail) v.status = STAT_SHAPE;
        else if (it.claimed_print != it.computed_print) v.status = STAT_PRINT;
        else if (seq_mode != MODE_SYNCED) v.status = STAT_SNAPSHOT;
        else if (it.first_seq == seq_confirmed) begin
          v.deliver = 1'b1;
          if (!it.consumer_ok) begin
            force_snapshot();
            v.status = STAT_CONSUMER;
          end else begin
            seq_confirmed      = it.last_seq;
            win_first[win_ptr] = it.first_seq;
            win_last[win_ptr]  = it.last_seq;
            win_print[win_ptr] = it.claimed_print;
            win_ok[win_ptr]    = 1'b1;
            win_ptr            = win_ptr + 1'b1;
            rec.first_seq = it.first_seq;
            rec.last_seq  = it.last_seq;
            rec.print     = it.claimed_print;
            applied_log.push_back(rec);
            if (applied_log.size() > LOG_DEPTH) void'(applied_log.pop_front());
          end
        end else if (it.first_seq < seq_confirmed) begin
          if (it.last_seq > seq_confirmed) v.status = STAT_OVERLAP;
          else begin
            // newest matching start wins
            hit = -1;
            for (k = 1; k <= WIN_DEPTH; k++) begin
              slot = win_ptr - WIN_IDX_W'(k);
              if (hit < 0 && win_ok[slot] && win_first[slot] == it.first_seq) hit = int'(slot);
            end
            if (hit < 0) v.status = STAT_STALE;
            else if (win_last[hit] == it.last_seq && win_print[hit] == it.claimed_print)
              v.status = STAT_DUPLICATE;
            else v.status = STAT_CONFLICT;
          end
        end else begin
          force_snapshot();
          v.status = STAT_GAP;
        end
      end
      OP_BASELINE: begin
        seq_confirmed = it.baseline_seq;
        seq_mode      = MODE_SYNCED;
        flush_window();
      end
      OP_SNAPSHOT: force_snapshot();
      default: begin
        seq_mode      = MODE_AWAIT;
        seq_confirmed = '0;
        flush_window();
      end
    endcase
    v.mode      = seq_mode;
    v.confirmed = seq_confirmed;
    return v;
  endfunction

  function automatic batch_item_t rand_item();
    batch_item_t it;
    it.op             = 2'($urandom);
    it.component      = $urandom;
    it.first_seq      = rand64();
    it.last_seq       = rand64();
    it.num_events     = $urandom;
    it.claimed_print  = rand64();
    it.computed_print = rand64();
    it.consumer_ok    = 1'($urandom);
    it.baseline_seq   = rand64();
    return it;
  endfunction

  function automatic batch_item_t make_header(input logic [63:0] first_seq,
                                              input logic [31:0] count);
    batch_item_t it;
    it = rand_item();
    it.op             = OP_BATCH;
    it.component      = cfg_owner;
    it.first_seq      = first_seq;
    it.num_events     = count;
    it.last_seq       = first_seq + {32'd0, count};
    it.computed_print = it.claimed_print;
    it.consumer_ok    = 1'b1;
    return it;
  endfunction

  function automatic batch_item_t control_item(input logic [1:0] op,
                                               input logic [63:0] base);
    batch_item_t it;
    it = rand_item();
    it.op           = op;
    it.baseline_seq = base;
    return it;
  endfunction

  function automatic logic [63:0] pick_seq();
    case ($urandom_range(0, 3))
      0:       return 64'($urandom_range(0, 100));
      1:       return 64'hFFFF_FFFF_FFFF_FFFF - 64'($urandom_range(0, 3000));
      default: return rand64();
    endcase
  endfunction

  // mostly short batches, now and then up to the configured limit
  function automatic logic [31:0] pick_count();
    int unsigned top;
    top = (cfg_max_events == '0) ? 1 : cfg_max_events;
    if ($urandom_range(0, 19) != 0 && top > 40) top = 40;
    return $urandom_range(1, top);
  endfunction

  task automatic note_mismatch(input string what, input logic [63:0] want,
                               input logic [63:0] got);
    mismatch_cnt++;
    if (mismatch_cnt <= 10)
      $display("  mismatch %0d: %s expected %0h got %0h at %0t ns",
               mismatch_cnt, what, want, got, $time);
  endtask

  task automatic push_item(input batch_item_t it);
    if (idle_en && $urandom_range(0, 3) == 0) begin
      s_axis_tvalid <= 1'b0;
      repeat ($urandom_range(1, 5)) @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tuser  <= it.op;
    s_axis_tdata  <= {7'd0, it.baseline_seq, it.consumer_ok, it.computed_print,
                      it.claimed_print, it.num_events, it.last_seq, it.first_seq,
                      it.component};
    do @(posedge clk_i); while (!s_axis_tready);
    pending_verdicts.push_back(advance_stream(it));
    items_sent++;
  endtask

  task automatic wait_drained();
    s_axis_tvalid <= 1'b0;
    while (pending_verdicts.size() != 0) @(posedge clk_i);
  endtask

  // write one register while the sequencer is idle, then read it back
  task automatic write_reg(input logic [2:0] addr, input logic [31:0] val);
    logic [31:0] want;
    wait_drained();
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= addr;
    pwdata  <= val;
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    if (addr == REG_OWNER_ID) begin
      cfg_owner = val;
      want      = val;
    end else begin
      cfg_max_events = val[15:0];
      want           = {16'd0, val[15:0]};
    end
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    if (prdata !== want) note_mismatch("register readback", 64'(want), 64'(prdata));
    psel    <= 1'b0;
    penable <= 1'b0;
    @(posedge clk_i);
    cfg_writes++;
  endtask

  // owner_id is 0 after reset: a zero component passes identity, fails the id check
  task automatic test_reset_state();
    batch_item_t it;
    it = make_header(rand64(), 32'd4);
    push_item(it);
    it.component = 32'd5;
    push_item(it);
    push_item(control_item(OP_SNAPSHOT, rand64()));   // ignored while awaiting baseline
    write_reg(REG_OWNER_ID, 32'hFFFF_FFFF);
  endtask

  task automatic test_header_checks();
    batch_item_t it;
    push_item(control_item(OP_BASELINE, 64'd1000));
    push_item(make_header(64'd1000, 32'd0));
    push_item(make_header(64'd1000, 32'd257));
    push_item(make_header(64'd1000, 32'hFFFF_FFFF));
    it = make_header(64'd1000, 32'd8);
    it.last_seq = it.last_seq + 64'd1;
    push_item(it);
    it = make_header(64'd1000, 32'd8);
    it.computed_print = ~it.claimed_print;
    push_item(it);
  endtask

  task automatic test_sequencing();
    batch_item_t it;
    logic [63:0] fp_a;
    it = make_header(64'd1000, 32'd10);
    fp_a = it.claimed_print;
    push_item(it);
    push_item(make_header(64'd1010, 32'd10));
    it = make_header(64'd1000, 32'd10);
    it.claimed_print  = fp_a;
    it.computed_print = fp_a;
    push_item(it);                                     // duplicate
    it.claimed_print  = ~fp_a;
    it.computed_print = ~fp_a;
    push_item(it);                                     // conflict
    push_item(make_header(64'd1015, 32'd10));          // overlap
    push_item(make_header(64'd1002, 32'd2));           // stale
    it = make_header(64'd1020, 32'd5);
    it.consumer_ok = 1'b0;
    push_item(it);                                     // consumer refuses
    push_item(make_header(64'd1020, 32'd5));           // needs snapshot
    push_item(control_item(OP_BASELINE, 64'd2000));
    push_item(make_header(64'd2100, 32'd10));          // gap
    push_item(control_item(OP_BASELINE, 64'hFFFF_FFFF_FFFF_FFFC));
    push_item(make_header(64'hFFFF_FFFF_FFFF_FFFC, 32'd8));  // wraps to 4
    push_item(make_header(64'hFFFF_FFFF_FFFF_FFFC, 32'd8));  // now ahead of 4: gap
    push_item(control_item(OP_BASELINE, 64'd500));
    push_item(control_item(OP_SNAPSHOT, rand64()));
    push_item(control_item(OP_SESSION, rand64()));
  endtask

  task automatic test_count_limits();
    write_reg(REG_MAX_EVENTS, 32'd0);
    push_item(control_item(OP_BASELINE, 64'd0));
    push_item(make_header(64'd0, 32'd1));
    write_reg(REG_MAX_EVENTS, 32'hFFFF_FFFF);
    push_item(make_header(64'd0, 32'd65535));
    push_item(make_header(64'd65535, 32'd65536));
  endtask

  task automatic test_random_traffic(input int chunks);
    batch_item_t    it;
    applied_range_t rng;
    logic [31:0]    owner;
    logic [31:0]    cnt;
    logic [15:0]    maxev;
    int             chunk;
    int             n;
    int             r;
    int             d;
    for (chunk = 0; chunk < chunks; chunk++) begin
      owner = $urandom;
      if (owner == '0) owner = 32'd1;
      maxev = 16'd256;
      case (chunk)
        0: ;
        1: begin
          owner = 32'hFFFF_FFFF;
          maxev = 16'hFFFF;
        end
        2: maxev = 16'd1;
        3: owner = '0;
        4: maxev = '0;
        default:
          case ($urandom_range(0, 3))
            0:       maxev = 16'($urandom_range(1, 300));
            1:       maxev = 16'hFFFF;
            2:       maxev = 16'($urandom_range(1, 65535));
            default: maxev = 16'($urandom_range(16, 64));
          endcase
      endcase
      write_reg(REG_OWNER_ID, owner);
      write_reg(REG_MAX_EVENTS, {16'($urandom), maxev});
      idle_en = (chunk < chunks - 3) && ($urandom_range(0, 4) != 0);
      for (n = 0; n < 100; n++) begin
        r = $urandom_range(0, 99);
        if (seq_mode != MODE_SYNCED && $urandom_range(0, 3) != 0) r = 94;  // resync
        cnt = pick_count();
        it  = make_header(seq_confirmed, cnt);
        if (r < 2) it.consumer_ok = 1'b0;
        else if (r < 55) ;
        else if (r < 67) begin
          // replay of an applied range, exact or altered
          if (applied_log.size() != 0) begin
            rng = applied_log[$urandom_range(0, applied_log.size() - 1)];
            it  = make_header(rng.first_seq, 32'(rng.last_seq - rng.first_seq));
            it.claimed_print  = rng.print;
            it.computed_print = rng.print;
            case ($urandom_range(0, 3))
              2: begin
                it.claimed_print ^= 64'd1 << $urandom_range(0, 63);
                it.computed_print = it.claimed_print;
              end
              3: begin
                it.num_events = it.num_events - 32'd1;
                it.last_seq   = it.last_seq - 64'd1;
              end
              default: ;
            endcase
          end
        end else if (r < 71) begin
          if (cnt >= 2 && seq_confirmed >= 64'(cnt)) begin
            d  = $urandom_range(1, cnt - 1);
            it = make_header(seq_confirmed - 64'(d), cnt);
          end
        end else if (r < 74) begin
          d = cnt + $urandom_range(0, 100);
          if (seq_confirmed >= 64'(d)) it = make_header(seq_confirmed - 64'(d), cnt);
        end else if (r < 76)
          it = make_header(seq_confirmed + 64'd1 + 64'($urandom_range(0, 500)), cnt);
        else if (r < 88) begin
          case ($urandom_range(0, 5))
            0: begin
              it.component = $urandom;
              if (it.component == cfg_owner) it.component = ~cfg_owner;
            end
            1: it.component = '0;
            2: it.num_events = '0;
            3: it.num_events = $urandom_range(0, 1) ? {16'd0, cfg_max_events} + 32'd1
                                                    : ($urandom | 32'h0001_0000);
            4: it.last_seq ^= 64'd1 << $urandom_range(0, 63);
            default: it.computed_print ^= 64'd1 << $urandom_range(0, 63);
          endcase
        end
        else if (r < 92) it = control_item(OP_SNAPSHOT, rand64());
        else if (r < 94) it = control_item(OP_SESSION, rand64());
        else if (r < 97) it = control_item(OP_BASELINE, pick_seq());
        else it = rand_item();
        push_item(it);
      end
    end
  endtask

  // result side: random stall bursts, and tready always comes back high between them
  always @(posedge clk_i) begin
    if (!rst_ni) begin
      m_axis_tready <= 1'b1;
      stall_left    <= 0;
    end else if (stall_left != 0) begin
      m_axis_tready <= (stall_left == 1);
      stall_left    <= stall_left - 1;
    end else if (idle_en && $urandom_range(0, 5) == 0) begin
      m_axis_tready <= 1'b0;
      stall_left    <= $urandom_range(1, 5);
    end else begin
      m_axis_tready <= 1'b1;
    end
  end

  always @(posedge clk_i) begin : check_results
    verdict_t want;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      if (pending_verdicts.size() == 0)
        note_mismatch("result beat with nothing pending", '0, 64'(m_axis_tdata));
      else begin
        want = pending_verdicts.pop_front();
        results_checked++;
        status_hits[want.status]++;
        if (m_axis_tdata[3:0] !== want.status)
          note_mismatch("status", 64'(want.status), 64'(m_axis_tdata[3:0]));
        if (m_axis_tdata[4] !== want.deliver)
          note_mismatch("deliver", 64'(want.deliver), 64'(m_axis_tdata[4]));
        if (m_axis_tdata[6:5] !== want.mode)
          note_mismatch("stream_mode", 64'(want.mode), 64'(m_axis_tdata[6:5]));
        if (m_axis_tdata[70:7] !== want.confirmed)
          note_mismatch("confirmed_out", want.confirmed, m_axis_tdata[70:7]);
      end
    end
  end

  initial begin
    #3_000_000;
    $display("event_batch_receive_sequencer_top verification failed");
    $finish;
  end

  initial begin : run_tests
    int kinds;
    seq_mode      = MODE_AWAIT;
    seq_confirmed = '0;
    flush_window();
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_reset_state();
    test_header_checks();
    test_sequencing();
    test_count_limits();
    test_random_traffic(21);
    wait_drained();
    repeat (40) @(posedge clk_i);
    kinds = 0;
    foreach (status_hits[i]) if (status_hits[i] != 0) kinds++;
    $display("Sent %0d items over %0d register writes, checked %0d results, %0d mismatches.",
             items_sent, cfg_writes, results_checked, mismatch_cnt);
    $display("Saw %0d of 13 status codes: %0d applied, %0d dup, %0d conflict, %0d stale, %0d gap.",
             kinds, status_hits[STAT_APPLIED], status_hits[STAT_DUPLICATE],
             status_hits[STAT_CONFLICT], status_hits[STAT_STALE], status_hits[STAT_GAP]);
    if (mismatch_cnt == 0)
      $display("event_batch_receive_sequencer_top verification clean");
    else
      $display("event_batch_receive_sequencer_top verification failed");
    $finish;
  end

endmodule

FILE: sim.f
hw/rtl/ebrs_pkg.sv
hw/rtl/ebrs_alu.sv
hw/rtl/ebrs_window.sv
hw/rtl/event_batch_receive_sequencer_top.sv
tb/tb_top.sv
